[sv/ple_pkg.sv]
// shared types and constants for the positional list engine
`default_nettype none

package ple_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // broadcast command to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
    logic fnd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/positional_list_engine.sv]
// top level: request control and the row of list cells
`default_nettype none

// Ordered list of up to CAPACITY entries kept in a row of cells, one entry per
// cell. A request is taken when start is high and busy is low; its result is
// shown for one cycle with done high and cannot be held off. Insert, delete,
// clear, unused kind codes and any request with a bad position give their
// result straight from the execute state, since every cell shifts in the same
// cycle. A valid read and every find send a probe token down the row, one cell
// per cycle, and the result is shown once the token has left the last cell, so
// the row length sets the wait. busy stays high until the result is shown,
// and a new request can be taken in the cycle that shows it.
module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [ple_pkg::KIND_W-1:0]    kind,
  input  wire [ple_pkg::POS_W-1:0]     position,
  input  wire [ple_pkg::VALUE_W-1:0]   value,
  output logic                         done,
  output logic                         status,
  output logic [ple_pkg::VALUE_W-1:0]  read_value,
  output logic [ple_pkg::POS_W-1:0]    found_position,
  output logic [ple_pkg::POS_W-1:0]    length,
  output logic                         is_empty
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;
  localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [CW-1:0] LAST_STEP = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t                state;
  logic [KIND_W-1:0]     kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [CW-1:0]         count;
  logic [CW-1:0]         step;

  logic [XW-1:0]         value_ext;
  logic [LW-1:0]         pos_ext;
  logic [LW-1:0]         count_ext;
  logic [LW-1:0]         pos_m1;
  logic [CW-1:0]         pos_idx;
  logic                  pos_nz;
  logic                  ins_ok;
  logic                  del_ok;
  logic                  rd_ok;
  logic [CW-1:0]         count_next;
  logic [LW-1:0]         len_ext;
  logic [LW-1:0]         fpos_ext;
  logic [XW-1:0]         rdata_ext;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic                  hit     [CAPACITY];
  logic [DATA_WIDTH-1:0] tdata   [CAPACITY];
  logic [CW-1:0]         tpos    [CAPACITY];

  assign value_ext = XW'(value);
  assign pos_ext   = LW'(pos_r);
  assign count_ext = LW'(count);
  assign pos_m1    = pos_ext - LW'(1);
  assign pos_idx   = pos_m1[CW-1:0];
  assign pos_nz    = (pos_ext != '0);

  assign ins_ok = (kind_r == KIND_INSERT) && pos_nz && (pos_m1 <= count_ext) &&
                  (count_ext < CAP_L);
  assign del_ok = (kind_r == KIND_DELETE) && pos_nz && (pos_m1 < count_ext);
  assign rd_ok  = (kind_r == KIND_READ) && pos_nz && (pos_m1 < count_ext);

  always_comb begin
    count_next = count;
    if (state == S_EXEC) begin
      if (ins_ok) begin
        count_next = count + CW'(1);
      end else if (del_ok) begin
        count_next = count - CW'(1);
      end else if (kind_r == KIND_CLEAR) begin
        count_next = '0;
      end
    end
  end

  always_comb begin
    ctrl     = '0;
    ctrl.ins = (state == S_EXEC) && ins_ok;
    ctrl.del = (state == S_EXEC) && del_ok;
    ctrl.rd  = (state == S_SCAN) && (kind_r == KIND_READ);
    ctrl.fnd = (state == S_SCAN) && (kind_r == KIND_FIND);
  end

  assign len_ext   = LW'(count_next);
  assign fpos_ext  = LW'(tpos[CAPACITY-1]);
  assign rdata_ext = XW'(tdata[CAPACITY-1]);
  assign busy      = (state != S_IDLE);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_e;
      logic [DATA_WIDTH-1:0] right_e;
      logic                  hin;
      logic [DATA_WIDTH-1:0] din;
      logic [CW-1:0]         pin;

      if (gi == 0) begin : g_head
        assign left_e = entries[gi];
        assign hin    = 1'b0;
        assign din    = '0;
        assign pin    = '0;
      end else begin : g_body
        assign left_e = entries[gi-1];
        assign hin    = hit[gi-1];
        assign din    = tdata[gi-1];
        assign pin    = tpos[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_e = entries[gi];
      end else begin : g_mid
        assign right_e = entries[gi+1];
      end

      ple_cell #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (gi),
        .CW         (CW)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .pos_idx     (pos_idx),
        .count       (count),
        .key         (key_r),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry       (entries[gi]),
        .hit_in      (hin),
        .data_in     (din),
        .tpos_in     (pin),
        .hit_out     (hit[gi]),
        .data_out    (tdata[gi]),
        .tpos_out    (tpos[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            pos_r  <= position;
            key_r  <= value_ext[DATA_WIDTH-1:0];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          step <= '0;
          if (rd_ok || (kind_r == KIND_FIND)) begin
            state <= S_SCAN;
          end else begin
            state          <= S_IDLE;
            done           <= 1'b1;
            status         <= !(ins_ok || del_ok || (kind_r == KIND_CLEAR));
            read_value     <= '0;
            found_position <= '0;
            length         <= len_ext[POS_W-1:0];
            is_empty       <= (count_next == '0);
          end
        end
        S_SCAN: begin
          step <= step + CW'(1);
          // token leaving the last cell has seen the whole row
          if (step == LAST_STEP) begin
            state          <= S_IDLE;
            done           <= 1'b1;
            status         <= !hit[CAPACITY-1];
            read_value     <= (kind_r == KIND_READ) ? rdata_ext[VALUE_W-1:0] : '0;
            found_position <= (kind_r == KIND_FIND) ? fpos_ext[POS_W-1:0] : '0;
            length         <= len_ext[POS_W-1:0];
            is_empty       <= (count == '0);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ple_cell.sv]
// one list slot: holds an entry, shifts on insert/delete, passes the probe token on
`default_nettype none

module ple_cell #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0,
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  wire                  clk,
  input  ple_pkg::cell_ctrl_t  ctrl,
  input  wire [CW-1:0]         pos_idx,
  input  wire [CW-1:0]         count,
  input  wire [DATA_WIDTH-1:0] key,
  input  wire [DATA_WIDTH-1:0] left_entry,
  input  wire [DATA_WIDTH-1:0] right_entry,
  output logic [DATA_WIDTH-1:0] entry,
  input  wire                  hit_in,
  input  wire [DATA_WIDTH-1:0] data_in,
  input  wire [CW-1:0]         tpos_in,
  output logic                 hit_out,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [CW-1:0]        tpos_out
);
  import ple_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX + 1);

  logic local_hit;

  assign local_hit = (ctrl.rd && (MY_IDX == pos_idx)) ||
                     (ctrl.fnd && (MY_IDX < count) && (entry == key));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == pos_idx) begin
        entry <= key;
      end else if (MY_IDX > pos_idx) begin
        entry <= left_entry;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= pos_idx) begin
        entry <= right_entry;
      end
    end
  end

  // probe token: the first hit along the row wins and rides to the end
  always_ff @(posedge clk) begin
    if (hit_in) begin
      hit_out  <= 1'b1;
      data_out <= data_in;
      tpos_out <= tpos_in;
    end else if (local_hit) begin
      hit_out  <= 1'b1;
      data_out <= entry;
      tpos_out <= MY_POS;
    end else begin
      hit_out  <= 1'b0;
      data_out <= '0;
      tpos_out <= '0;
    end
  end

endmodule

`default_nettype wire

[sv/ple_checker.sv]
// port-level checks for the positional list engine and their binding
`default_nettype none

module ple_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        status,
  input wire [4:0]  found_position,
  input wire [4:0]  length,
  input wire        is_empty
);

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (length == 5'd0)))
    else $error("is_empty disagrees with length");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (found_position != 5'd0)) |-> (status == 1'b0))
    else $error("found position given with error status");

  // every item passes through the execute state after acceptance, so results never come back to back
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .found_position (found_position),
  .length         (length),
  .is_empty       (is_empty)
);

`default_nettype wire
